// ===== src/gcre_pkg.sv =====
// Shared constants, types and helpers for the grid cell range enumerator.
`default_nettype none

package gcre_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int MAX_CELLS   = 64;
    localparam int COORD_WIDTH = 24;

    localparam int HALF_W  = 23;
    localparam int INV_W   = 24;
    localparam int SIDE_W  = 7;
    localparam int INDEX_W = 12;
    localparam int CFG_W   = 24;
    localparam int FRAC_SH = 24;

    localparam int CELL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int T_W    = ((COORD_WIDTH + 2 > HALF_W + 1) ? COORD_WIDTH + 2 : HALF_W + 1) + 1;
    localparam int P_W    = T_W + INV_W + 1;
    localparam int CNT_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS + 1) : 1;
    localparam int TOT_W  = 2 * (CELL_W + 1);

    localparam logic [1:0] CFG_HALF = 2'd0;
    localparam logic [1:0] CFG_INV  = 2'd1;
    localparam logic [1:0] CFG_SIDE = 2'd2;

    typedef logic signed [T_W-1:0] t_tcoord;
    typedef logic [CELL_W-1:0]     t_cell;

    typedef struct packed {
        t_tcoord [3:0] x;
        t_tcoord [3:0] y;
    } t_corners;

    typedef struct packed {
        t_cell [3:0] x;
        t_cell [3:0] y;
    } t_cells;

    typedef struct packed {
        t_cell x0;
        t_cell x1;
        t_cell y0;
        t_cell y1;
    } t_bounds;

    typedef struct packed {
        t_cell               x0;
        t_cell               x1;
        logic [INDEX_W-1:0]  base;
        logic [CNT_W-1:0]    rem;
        logic                over;
    } t_range;

    // Limit the side count to 1..MAX_SIDE.
    function automatic logic [SIDE_W-1:0] f_side_eff(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIDE_W'(1);
        end else if (int'(s) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/gcre_front.sv =====
// Corner stage: start and end box corners offset by half the grid width.
`default_nettype none

module gcre_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_move_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_move_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_lo_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_lo_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_hi_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_hi_y,
    input  logic        [gcre_pkg::HALF_W-1:0]      i_half,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output gcre_pkg::t_corners                      o_corners
);
    import gcre_pkg::*;

    t_tcoord  w_px, w_py, w_mx, w_my, w_lx, w_ly, w_hx, w_hy, w_half;
    t_corners n_corners;
    t_corners r_corners;
    logic     r_valid;

    assign w_px   = T_W'(i_pos_x);
    assign w_py   = T_W'(i_pos_y);
    assign w_mx   = T_W'(i_move_x);
    assign w_my   = T_W'(i_move_y);
    assign w_lx   = T_W'(i_box_lo_x);
    assign w_ly   = T_W'(i_box_lo_y);
    assign w_hx   = T_W'(i_box_hi_x);
    assign w_hy   = T_W'(i_box_hi_y);
    assign w_half = T_W'(i_half);

    always_comb begin
        n_corners.x[0] = w_px + w_lx + w_half;
        n_corners.x[1] = w_px + w_hx + w_half;
        n_corners.x[2] = w_px + w_lx + w_mx + w_half;
        n_corners.x[3] = w_px + w_hx + w_mx + w_half;
        n_corners.y[0] = w_py + w_ly + w_half;
        n_corners.y[1] = w_py + w_hy + w_half;
        n_corners.y[2] = w_py + w_ly + w_my + w_half;
        n_corners.y[3] = w_py + w_hy + w_my + w_half;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_corners <= n_corners;
        end
    end

    assign o_valid   = r_valid;
    assign o_corners = r_corners;

endmodule

`default_nettype wire

// ===== src/gcre_map.sv =====
// Cell mapping stages: scale by the inverse cell size, then floor and clamp.
`default_nettype none

module gcre_map (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  gcre_pkg::t_corners               i_corners,
    input  logic [gcre_pkg::INV_W-1:0]       i_inv,
    input  logic [gcre_pkg::SIDE_W-1:0]      i_side,
    output logic                             o_valid,
    input  logic                             i_ready,
    output gcre_pkg::t_cells                 o_cells
);
    import gcre_pkg::*;

    logic signed [INV_W:0]  w_inv;
    logic signed [P_W-1:0]  n_prod_x [4];
    logic signed [P_W-1:0]  n_prod_y [4];
    logic signed [P_W-1:0]  r_prod_x [4];
    logic signed [P_W-1:0]  r_prod_y [4];
    logic                   r_a_valid;
    logic                   w_a_ready;
    t_cells                 n_cells;
    t_cells                 r_cells;
    logic                   r_b_valid;
    logic                   w_b_ready;

    function automatic t_cell f_clamp(input logic signed [P_W-1:0] p,
                                      input logic [SIDE_W-1:0] s);
        logic [P_W-FRAC_SH-1:0] q;
        logic [SIDE_W-1:0]      lim;
        t_cell                  r;
        q   = p[P_W-1:FRAC_SH];
        lim = s - 1'b1;
        if (p[P_W-1]) begin
            r = '0;
        end else if (q > P_W'(lim)) begin
            r = CELL_W'(lim);
        end else begin
            r = CELL_W'(q);
        end
        return r;
    endfunction

    assign w_inv = {1'b0, i_inv};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_prod_x[i] = $signed(i_corners.x[i]) * w_inv;
            n_prod_y[i] = $signed(i_corners.y[i]) * w_inv;
        end
    end

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_cells.x[i] = f_clamp(r_prod_x[i], i_side);
            n_cells.y[i] = f_clamp(r_prod_y[i], i_side);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            r_cells <= n_cells;
        end
    end

    assign o_valid = r_b_valid;
    assign o_cells = r_cells;

endmodule

`default_nettype wire

// ===== src/gcre_bound.sv =====
// Range stages: min and max cell per axis, then cell count and first row base.
`default_nettype none

module gcre_bound (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gcre_pkg::t_cells              i_cells,
    input  logic [gcre_pkg::SIDE_W-1:0]   i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gcre_pkg::t_range              o_range
);
    import gcre_pkg::*;

    t_bounds                                n_bounds;
    t_bounds                                r_bounds;
    logic                                   r_c_valid;
    logic                                   w_c_ready;
    t_cell                                  w_lo_x [2];
    t_cell                                  w_hi_x [2];
    t_cell                                  w_lo_y [2];
    t_cell                                  w_hi_y [2];
    logic [CELL_W:0]                        w_width;
    logic [CELL_W:0]                        w_height;
    logic [TOT_W-1:0]                       w_total;
    logic                                   w_over;
    logic [CNT_W-1:0]                       w_count;
    logic [INDEX_W+CELL_W+SIDE_W-1:0]       w_base_full;
    t_range                                 n_range;
    t_range                                 r_range;
    logic                                   r_d_valid;
    logic                                   w_d_ready;

    function automatic t_cell f_min(input t_cell a, input t_cell b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_cell f_max(input t_cell a, input t_cell b);
        return (a > b) ? a : b;
    endfunction

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_lo_x[i] = f_min(i_cells.x[2*i], i_cells.x[2*i+1]);
            w_hi_x[i] = f_max(i_cells.x[2*i], i_cells.x[2*i+1]);
            w_lo_y[i] = f_min(i_cells.y[2*i], i_cells.y[2*i+1]);
            w_hi_y[i] = f_max(i_cells.y[2*i], i_cells.y[2*i+1]);
        end
        n_bounds.x0 = f_min(w_lo_x[0], w_lo_x[1]);
        n_bounds.x1 = f_max(w_hi_x[0], w_hi_x[1]);
        n_bounds.y0 = f_min(w_lo_y[0], w_lo_y[1]);
        n_bounds.y1 = f_max(w_hi_y[0], w_hi_y[1]);
    end

    always_comb begin
        w_width     = {1'b0, r_bounds.x1} - {1'b0, r_bounds.x0} + 1'b1;
        w_height    = {1'b0, r_bounds.y1} - {1'b0, r_bounds.y0} + 1'b1;
        w_total     = w_width * w_height;
        w_over      = w_total > TOT_W'(MAX_CELLS);
        w_count     = w_over ? CNT_W'(MAX_CELLS) : CNT_W'(w_total);
        w_base_full = r_bounds.y0 * i_side;
        n_range.x0   = r_bounds.x0;
        n_range.x1   = r_bounds.x1;
        n_range.base = w_base_full[INDEX_W-1:0];
        n_range.rem  = w_count - 1'b1;
        n_range.over = w_over;
    end

    assign w_d_ready = !r_d_valid || i_ready;
    assign w_c_ready = !r_c_valid || w_d_ready;
    assign o_ready   = w_c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_c_ready) begin
                r_c_valid <= i_valid;
            end
            if (w_d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && i_valid) begin
            r_bounds <= n_bounds;
        end
        if (w_d_ready && r_c_valid) begin
            r_range <= n_range;
        end
    end

    assign o_valid = r_d_valid;
    assign o_range = r_range;

endmodule

`default_nettype wire

// ===== src/gcre_scan.sv =====
// Scanner: cells go row by row into the output register, one per cycle unless stalled.
`default_nettype none

module gcre_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  gcre_pkg::t_range               i_range,
    input  logic [gcre_pkg::SIDE_W-1:0]    i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [gcre_pkg::INDEX_W-1:0]   o_cell_index,
    output logic                           o_last_cell,
    output logic                           o_overflowed
);
    import gcre_pkg::*;

    logic                r_busy;
    t_cell               r_x;
    t_cell               r_x0;
    t_cell               r_x1;
    logic [INDEX_W-1:0]  r_base;
    logic [CNT_W-1:0]    r_rem;
    logic                r_over;
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic                r_out_last;
    logic                r_out_over;
    logic                w_emit;
    logic                w_last_emit;
    logic                w_load;

    assign w_emit      = r_busy && (!r_out_valid || i_ready);
    assign w_last_emit = w_emit && (r_rem == '0);
    assign o_ready     = !r_busy || w_last_emit;
    assign w_load      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_last_emit) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x    <= i_range.x0;
            r_x0   <= i_range.x0;
            r_x1   <= i_range.x1;
            r_base <= i_range.base;
            r_rem  <= i_range.rem;
            r_over <= i_range.over;
        end else if (w_emit) begin
            r_rem <= r_rem - 1'b1;
            if (r_x == r_x1) begin
                r_x    <= r_x0;
                r_base <= r_base + INDEX_W'(i_side);
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= r_base + INDEX_W'(r_x);
            r_out_last  <= (r_rem == '0);
            r_out_over  <= r_over;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_index = r_out_index;
    assign o_last_cell  = r_out_last;
    assign o_overflowed = r_out_over;

endmodule

`default_nettype wire

// ===== src/grid_cell_range_enumerator.sv =====
// Top level of the grid cell range enumerator: configuration registers and stage chain.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one item: position, motion delta and
//   box extent in X and Y, each signed Q15.8. Output channel (o_valid / i_ready)
//   gives one cell index per cell of an item, row by row; o_last_cell marks
//   the final cell of an item and o_overflowed is set on every cell of an
//   item whose range held more than MAX_CELLS cells and was cut.
//   Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
//   high (0 half grid width, 1 inverse cell size, 2 side count); other
//   indexes are ignored. Write only while the block is idle.
//   Path: the first cell of an item passes five pipeline stages and the
//   scanner load, then the output register.
//   Throughput: one cell per cycle while i_ready stays high; the row scanner
//   is the one element that works on a single item at a time. Up to five
//   further items wait in the pipeline stages meanwhile.
//   Reset: clears all valid bits; registers return to half grid 0, inverse
//   cell size 1.0 and 64 cells per side. No clearing pass is needed.
//   Stall: when i_ready is low the output holds and the stages fill, then
//   o_ready drops; nothing is lost or repeated.
`default_nettype none

module grid_cell_range_enumerator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_move_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_move_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_lo_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_lo_y,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_hi_x,
    input  logic signed [gcre_pkg::COORD_WIDTH-1:0] i_box_hi_y,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic        [gcre_pkg::INDEX_W-1:0]     o_cell_index,
    output logic                                    o_last_cell,
    output logic                                    o_overflowed,
    input  logic                                    i_cfg_we,
    input  logic        [1:0]                       i_cfg_index,
    input  logic        [gcre_pkg::CFG_W-1:0]       i_cfg_data
);
    import gcre_pkg::*;

    logic [HALF_W-1:0]  r_half;
    logic [INV_W-1:0]   r_inv;
    logic [SIDE_W-1:0]  r_side;
    logic [SIDE_W-1:0]  w_side;

    logic      w_front_valid, w_front_ready;
    t_corners  w_corners;
    logic      w_map_valid, w_map_ready;
    t_cells    w_cells;
    logic      w_bound_valid, w_bound_ready;
    t_range    w_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= '0;
            r_inv  <= INV_W'(65536);
            r_side <= SIDE_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF: r_half <= i_cfg_data[HALF_W-1:0];
                CFG_INV:  r_inv  <= i_cfg_data[INV_W-1:0];
                CFG_SIDE: r_side <= i_cfg_data[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_side = f_side_eff(r_side);

    gcre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_move_x   (i_move_x),
        .i_move_y   (i_move_y),
        .i_box_lo_x (i_box_lo_x),
        .i_box_lo_y (i_box_lo_y),
        .i_box_hi_x (i_box_hi_x),
        .i_box_hi_y (i_box_hi_y),
        .i_half     (r_half),
        .o_valid    (w_front_valid),
        .i_ready    (w_front_ready),
        .o_corners  (w_corners)
    );

    gcre_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_front_valid),
        .o_ready   (w_front_ready),
        .i_corners (w_corners),
        .i_inv     (r_inv),
        .i_side    (w_side),
        .o_valid   (w_map_valid),
        .i_ready   (w_map_ready),
        .o_cells   (w_cells)
    );

    gcre_bound u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_valid),
        .o_ready (w_map_ready),
        .i_cells (w_cells),
        .i_side  (w_side),
        .o_valid (w_bound_valid),
        .i_ready (w_bound_ready),
        .o_range (w_range)
    );

    gcre_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_bound_valid),
        .o_ready      (w_bound_ready),
        .i_range      (w_range),
        .i_side       (w_side),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_index (o_cell_index),
        .o_last_cell  (o_last_cell),
        .o_overflowed (o_overflowed)
    );

`ifndef SYNTHESIS
    a_index_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({2'b00, o_cell_index} < (14'(w_side) * 14'(w_side))))
        else $error("cell index outside the grid");

    a_item_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_cell) |=>
            (o_valid && (o_overflowed == $past(o_overflowed))))
        else $error("item cut short or overflow flag changed within an item");

    a_next_cell_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_cell) |=>
            (o_cell_index != $past(o_cell_index)))
        else $error("cell repeated within an item");
`endif

endmodule

`default_nettype wire
